/* rtl/core/bfa_pkg.sv */
// Shared types and constants for the bitmap frame allocator.
// No dependencies.
`default_nettype none
package bfa_pkg;
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_RUN   = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_RSV   = 3'd3;
    localparam logic [2:0] OP_TEST  = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OOM   = 3'd1;
    localparam logic [2:0] ST_FREED = 3'd2;
    localparam logic [2:0] ST_USED  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam int WORD_BITS = 32;
    localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch request, set up first word
        logic clr_step;  // clearing pass: write all-ones at word index
        logic scan;      // evaluate read word for search
        logic wr_bit;    // write modified word back (single bit ops)
        logic run_wr;    // write marked word
        logic finish;    // produce result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic clr_last;
        logic is_run;    // effective op is a valid run alloc
        logic is_single;
        logic is_bitop;  // free/reserve/test in range
        logic scan_done; // search finished (hit or miss)
        logic hit;
        logic mark_last;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/core/bfa_ctrl.sv */
// Controller state machine for the bitmap frame allocator.
// Depends on bfa_pkg.
`default_nettype none
module bfa_ctrl import bfa_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DISP  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_MRD   = 9'b000100000,
        S_MWR   = 9'b001000000,
        S_BIT   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && !r_out_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_run || i_sts.is_single) begin
                    n_state = S_RD;
                end else if (i_sts.is_bitop) begin
                    n_state = S_BIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RD: n_state = S_SCAN;
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.hit) begin
                        n_state = S_MRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: begin
                o_cmd.run_wr = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_BIT: n_state = S_SCAN;
            S_OUT: begin
                if (!r_out_valid) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // bit ops: after S_BIT the read word is ready; reuse wr_bit
        if (r_state == S_SCAN && i_sts.is_bitop) begin
            o_cmd = '0;
            o_cmd.wr_bit = 1'b1;
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

/* rtl/core/bfa_dp.sv */
// Datapath of the bitmap frame allocator: used map memory, hint, count, search.
// Depends on bfa_pkg.
`default_nettype none
module bfa_dp import bfa_pkg::*; #(
    parameter int MAX_FRAMES = 65536,
    parameter int MAX_RUN    = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [16:0] i_cfg_data,
    input  wire  [2:0]  i_op,
    input  wire  [15:0] i_frame,
    input  wire  [10:0] i_run_length,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_frame,
    output logic        o_is_used,
    output logic [16:0] o_free_frames
);
    localparam int WORDS = MAX_FRAMES / WORD_BITS;
    localparam int AW = $clog2(WORDS);
    localparam int FW = $clog2(MAX_FRAMES);

    logic [31:0] mem [WORDS];
    logic [31:0] r_rdata;

    logic [16:0] r_frame_count;
    logic [15:0] r_hint;
    logic [16:0] r_free;
    logic [AW:0] r_widx;
    logic [2:0]  r_op;
    logic [15:0] r_frame;
    logic [10:0] r_len;
    logic [2:0]  r_status;
    logic [15:0] r_res;
    logic        r_isused;
    logic        r_run, r_single, r_bitop;
    logic [FW:0] r_cnt;      // current run length
    logic [FW:0] r_start;    // run start / found frame
    logic [10:0] r_left;     // frames left to mark
    logic [4:0]  r_boff;     // bit offset in marking word

    // effective limits
    logic [16:0] lim;
    logic [AW:0] nwords;
    assign lim = (32'(r_frame_count) > 32'(MAX_FRAMES)) ? 17'(MAX_FRAMES) : r_frame_count;
    assign nwords = (AW+1)'(lim >> 5);

    // lowest zero bit in word
    logic        w_has0;
    logic [4:0]  w_low0;
    always_comb begin
        w_has0 = 1'b0;
        w_low0 = '0;
        for (int b = 31; b >= 0; b--) begin
            if (!r_rdata[b]) begin
                w_has0 = 1'b1;
                w_low0 = 5'(b);
            end
        end
    end

    // run search over one word: free run ending at each bit, from the
    // position of the last used bit below it (or the carried count if none)
    logic        run_hit;
    logic [FW:0] run_end_cnt;
    logic [FW:0] run_s;
    always_comb begin
        logic [5:0]  last;   // one above the highest used bit so far
        logic        seen;
        logic [FW:0] c;
        run_hit = 1'b0;
        run_s = '0;
        last = '0;
        seen = 1'b0;
        c = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_rdata[b]) begin
                seen = 1'b1;
                last = 6'(b + 1);
            end
            c = seen ? (FW+1)'(6'(b + 1) - last) : r_cnt + (FW+1)'(b + 1);
            if (!run_hit && c == (FW+1)'(r_len)) begin
                run_hit = 1'b1;
                run_s = (FW+1)'({r_widx[AW-1:0], 5'(b)}) + 1'b1 - (FW+1)'(r_len);
            end
        end
        run_end_cnt = c;
    end

    // mark mask for run marking
    logic [31:0] mmask;
    logic [5:0]  mcount;
    always_comb begin
        mcount = (r_left > 11'(32 - 32'(r_boff))) ? 6'(32 - 32'(r_boff)) : 6'(r_left);
        mmask = (mcount == 6'd32) ? ALL_USED : ((32'd1 << mcount) - 32'd1);
        mmask = mmask << r_boff;
    end

    logic [AW-1:0] addr;
    assign addr = r_widx[AW-1:0];
    logic [4:0] fbit;
    assign fbit = r_frame[4:0];

    assign o_sts.clr_last  = (r_widx == (AW+1)'(WORDS - 1));
    assign o_sts.is_run    = r_run;
    assign o_sts.is_single = r_single;
    assign o_sts.is_bitop  = r_bitop;
    assign o_sts.scan_done = (r_widx >= nwords) || (r_single ? w_has0 : run_hit)
                             || (r_widx + 1'b1 >= nwords);
    assign o_sts.hit       = (r_widx < nwords) && (r_single ? w_has0 : run_hit);
    assign o_sts.mark_last = (r_left == 11'(mcount));

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) mem[addr] <= ALL_USED;
        else if (i_cmd.wr_bit && r_op != OP_TEST)
            mem[addr] <= (r_op == OP_FREE) ? (r_rdata & ~(32'd1 << fbit))
                                           : (r_rdata | (32'd1 << fbit));
        else if (i_cmd.run_wr) mem[addr] <= r_rdata | mmask;
        r_rdata <= mem[addr];
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_hint <= '0;
            r_free <= '0;
            r_widx <= '0;
            r_run <= 1'b0; r_single <= 1'b0; r_bitop <= 1'b0;
        end else begin
            if (i_cfg_we) r_frame_count <= i_cfg_data;
            if (i_cmd.clr_step) r_widx <= r_widx + 1'b1;
            if (i_cmd.load) begin
                r_op <= i_op; r_frame <= i_frame; r_len <= i_run_length;
                r_status <= ST_OK; r_res <= '0; r_isused <= 1'b0;
                r_cnt <= '0;
                r_single <= (i_op == OP_ALLOC) || (i_op == OP_RUN && i_run_length < 11'd2);
                r_run <= (i_op == OP_RUN) && i_run_length >= 11'd2
                         && 32'(i_run_length) <= 32'(MAX_RUN);
                r_bitop <= (i_op == OP_FREE || i_op == OP_RSV || i_op == OP_TEST)
                           && (17'(i_frame) < lim);
                if (i_op == OP_ALLOC || (i_op == OP_RUN && i_run_length < 11'd2))
                    r_widx <= ((AW+1)'(r_hint >> 5) != '0) ? (AW+1)'(r_hint >> 5) - 1'b1 : '0;
                else if (i_op == OP_RUN) r_widx <= '0;
                else r_widx <= (AW+1)'(i_frame >> 5);
                if (i_op == OP_RUN && i_run_length >= 11'd2 && 32'(i_run_length) > 32'(MAX_RUN))
                    r_status <= ST_RANGE;
                else if (i_op == OP_FREE || i_op == OP_RSV || i_op == OP_TEST) begin
                    if (17'(i_frame) >= lim) r_status <= ST_RANGE;
                end else if (i_op != OP_ALLOC && i_op != OP_RUN) r_status <= ST_RANGE;
            end
            if (i_cmd.scan && !r_bitop) begin
                if (o_sts.hit) begin
                    if (r_single) begin
                        r_start <= (FW+1)'({addr, w_low0});
                        r_left <= 11'd1;
                        r_boff <= w_low0;
                    end else begin
                        r_start <= run_s;
                        r_left <= r_len;
                        r_boff <= run_s[4:0];
                        r_widx <= (AW+1)'(run_s >> 5);
                    end
                end else if (o_sts.scan_done) begin
                    r_status <= ST_OOM;
                end else begin
                    r_cnt <= run_end_cnt;
                    r_widx <= r_widx + 1'b1;
                end
            end
            if (i_cmd.run_wr) begin
                r_left <= r_left - 11'(mcount);
                r_boff <= '0;
                r_widx <= r_widx + 1'b1;
                if (o_sts.mark_last) begin
                    r_res <= r_start[15:0];
                    r_free <= r_free - 17'(r_single ? 11'd1 : r_len);
                    if (r_single) r_hint <= r_start[15:0];
                end
            end
            if (i_cmd.wr_bit) begin
                case (r_op)
                    OP_FREE: begin
                        if (!r_rdata[fbit]) r_status <= ST_FREED;
                        else begin
                            r_free <= r_free + 1'b1;
                            r_hint <= '0;
                        end
                    end
                    OP_RSV: begin
                        if (r_rdata[fbit]) r_status <= ST_USED;
                        else r_free <= r_free - 1'b1;
                    end
                    default: r_isused <= r_rdata[fbit];
                endcase
            end
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status <= r_status;
            o_result_frame <= (r_status == ST_OK) ? r_res : '0;
            o_is_used <= r_isused && r_status == ST_OK;
            o_free_frames <= r_free;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bitmap_frame_allocator.sv */
// Top level of the bitmap frame allocator: controller plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp.
//
// Usage: one request channel (op, frame, run_length) and one result channel
// (status, result_frame, is_used, free_frames), both valid/ready. A config
// channel writes frame_count; the user must write it only while the block is
// idle, since the block itself does not enforce it. One transaction at a time.
// Test, free and reserve pass through the dispatch, bit-read and write-back
// states to the result; a request refused at once (out of range, unknown op,
// run too long) goes from dispatch straight to the result state.
// Allocation walks the map one 32-bit word at a time, reading each word in
// S_RD and evaluating it in S_SCAN, then marks the allocated run word by word
// through S_MRD and S_MWR. After reset a clearing pass writes all-ones into
// all MAX_FRAMES/32 words, one per cycle; no request is taken meanwhile.
// A result is held until taken; the next request can be taken in the cycle after.
`default_nettype none
module bitmap_frame_allocator import bfa_pkg::*; #(
    parameter int MAX_FRAMES = 65536,
    parameter int MAX_RUN    = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [16:0] i_frame_count,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_op,
    input  wire  [15:0] i_frame,
    input  wire  [10:0] i_run_length,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_frame,
    output logic        o_is_used,
    output logic [16:0] o_free_frames
);
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    bfa_dp #(.MAX_FRAMES(MAX_FRAMES), .MAX_RUN(MAX_RUN)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_we(i_cfg_valid), .i_cfg_data(i_frame_count),
        .i_op, .i_frame, .i_run_length,
        .i_cmd(cmd), .o_sts(sts),
        .o_status, .o_result_frame, .o_is_used, .o_free_frames
    );
endmodule
`default_nettype wire
